// ===== rtl/permutation_rank_unrank_defines.svh =====
// assertion macros shared by the rtl
`ifndef PERMUTATION_RANK_UNRANK_DEFINES_SVH
`define PERMUTATION_RANK_UNRANK_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PRUR_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("prur assertion failed");

// antecedent implies consequent in the next cycle
`define PRUR_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("prur assertion failed");

`endif

// ===== rtl/prur_pkg.sv =====
package prur_pkg;

  localparam int PERM_SIZE_DEF = 11;
  localparam int NIB_W         = 4;
  localparam int PERM_W        = 44;
  localparam int RANK_W        = 26;
  localparam int PERM_NIBS     = PERM_W / NIB_W;
  localparam int RECIP_W       = 32;

  typedef enum logic {
    REQ_RANK   = 1'b0,
    REQ_UNRANK = 1'b1
  } req_t;

  typedef struct packed {
    req_t req;
    logic bad;
  } ctl_t;

endpackage

// ===== rtl/prur_if.sv =====
interface prur_in_if;
  import prur_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [PERM_W-1:0] perm_in;
  logic [RANK_W-1:0] rank_in;

  modport source (output valid, req_type, perm_in, rank_in, input ready);
  modport sink (input valid, req_type, perm_in, rank_in, output ready);
endinterface

interface prur_out_if;
  import prur_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_out;
  logic [PERM_W-1:0] perm_out;
  logic              bad_perm;

  modport source (output valid, rank_out, perm_out, bad_perm, input ready);
  modport sink (input valid, rank_out, perm_out, bad_perm, output ready);
endinterface

// ===== rtl/prur_front.sv =====
module prur_front #(
  parameter int PERM_SIZE = prur_pkg::PERM_SIZE_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      up_valid,
  output logic                                      up_ready,
  input  logic                                      up_req,
  input  logic [prur_pkg::PERM_W-1:0]               up_perm,
  input  logic [prur_pkg::RANK_W-1:0]               up_rank,
  output logic                                      dn_valid,
  input  logic                                      dn_ready,
  output prur_pkg::ctl_t                            dn_ctl,
  output logic [PERM_SIZE-1:0][prur_pkg::NIB_W-1:0] dn_perm,
  output logic [prur_pkg::RANK_W-1:0]               dn_val
);
  import prur_pkg::*;

  localparam int PRES_W = 1 << NIB_W;
  localparam int CMP_W  = NIB_W + 1;

  logic [PERM_SIZE-1:0][NIB_W-1:0] nib;
  logic [PRES_W-1:0]               pres;
  logic                            out_rng;
  logic                            bad;

  logic                            valid_r;
  ctl_t                            ctl_r, ctl_nxt;
  logic [PERM_SIZE-1:0][NIB_W-1:0] perm_r, perm_nxt;
  logic [RANK_W-1:0]               val_r, val_nxt;

  // positions past the packed field read as zero
  for (genvar gi = 0; gi < PERM_SIZE; gi++) begin : g_nib
    if (gi < PERM_NIBS) begin : g_in
      assign nib[gi] = up_perm[gi*NIB_W +: NIB_W];
    end else begin : g_zero
      assign nib[gi] = '0;
    end
  end

  // a permutation has every value below the size present exactly once
  always_comb begin
    pres    = '0;
    out_rng = 1'b0;
    for (int i = 0; i < PERM_SIZE; i++) begin
      if ({1'b0, nib[i]} >= CMP_W'(PERM_SIZE)) out_rng = 1'b1;
      pres = pres | (PRES_W'(1) << nib[i]);
    end
    bad = out_rng || (pres[PERM_SIZE-1:0] != {PERM_SIZE{1'b1}});
  end

  always_comb begin
    ctl_nxt.req = up_req ? REQ_UNRANK : REQ_RANK;
    ctl_nxt.bad = !up_req && bad;
    for (int i = 0; i < PERM_SIZE; i++) begin
      perm_nxt[i] = up_req ? NIB_W'(i) : nib[i];
    end
    val_nxt = up_req ? up_rank : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctl_r  <= ctl_nxt;
      perm_r <= perm_nxt;
      val_r  <= val_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctl   = ctl_r;
  assign dn_perm  = perm_r;
  assign dn_val   = val_r;

endmodule

// ===== rtl/prur_slot.sv =====
module prur_slot #(
  parameter int PERM_SIZE = prur_pkg::PERM_SIZE_DEF,
  parameter int SLOT      = 0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      up_valid,
  output logic                                      up_ready,
  input  prur_pkg::ctl_t                            up_ctl,
  input  logic [PERM_SIZE-1:0][prur_pkg::NIB_W-1:0] up_perm,
  input  logic [prur_pkg::RANK_W-1:0]               up_val,
  output logic                                      dn_valid,
  input  logic                                      dn_ready,
  output prur_pkg::ctl_t                            dn_ctl,
  output logic [PERM_SIZE-1:0][prur_pkg::NIB_W-1:0] dn_perm,
  output logic [prur_pkg::RANK_W-1:0]               dn_val
);
  import prur_pkg::*;

  localparam int  IDX_W   = (PERM_SIZE > 1) ? $clog2(PERM_SIZE) : 1;
  localparam int  RANK_R  = PERM_SIZE - SLOT;
  localparam bit  UNR_ON  = (SLOT + 1 < PERM_SIZE);
  localparam int  UNR_IDX = UNR_ON ? SLOT + 1 : 0;
  localparam int  UNR_DIV = SLOT + 2;
  localparam int  PROD_W  = RANK_W + RECIP_W;
  localparam logic [RECIP_W-1:0] Recip = RECIP_W'((64'd1 << RECIP_W) / UNR_DIV);

  // stage a: rank search and swap, or reciprocal product for unrank
  logic [IDX_W-1:0]                m_rk;
  logic                            found;
  logic [PROD_W-1:0]               prod;
  logic [PERM_SIZE-1:0][NIB_W-1:0] a_perm_nxt;
  logic [RANK_W-1:0]               a_tmp_nxt;

  logic                            a_valid_r;
  ctl_t                            a_ctl_r;
  logic [PERM_SIZE-1:0][NIB_W-1:0] a_perm_r;
  logic [RANK_W-1:0]               a_val_r, a_tmp_r;
  logic                            a_ready;

  // stage b: rank fold, or quotient correction and swap for unrank
  logic [RANK_W-1:0]               mul_r;
  logic [RANK_W-1:0]               qd;
  logic [RANK_W-1:0]               rem;
  logic [RANK_W-1:0]               q;
  logic [IDX_W-1:0]                m_un;
  logic [PERM_SIZE-1:0][NIB_W-1:0] b_perm_nxt;
  logic [RANK_W-1:0]               b_val_nxt;

  logic                            b_valid_r;
  ctl_t                            b_ctl_r;
  logic [PERM_SIZE-1:0][NIB_W-1:0] b_perm_r;
  logic [RANK_W-1:0]               b_val_r;
  logic                            b_ready;

  always_comb begin
    m_rk  = '0;
    found = 1'b0;
    for (int j = 0; j < PERM_SIZE; j++) begin
      if (!found && (j < RANK_R) && (up_perm[j] == NIB_W'(RANK_R - 1))) begin
        m_rk  = IDX_W'(j);
        found = 1'b1;
      end
    end
    prod       = PROD_W'(up_val) * PROD_W'(Recip);
    a_perm_nxt = up_perm;
    if (up_ctl.req == REQ_RANK) begin
      a_perm_nxt[IDX_W'(RANK_R - 1)] = up_perm[m_rk];
      a_perm_nxt[m_rk]               = up_perm[IDX_W'(RANK_R - 1)];
      a_tmp_nxt                      = RANK_W'(m_rk);
    end else begin
      // estimate is the quotient or one below it
      a_tmp_nxt = prod[PROD_W-1:RECIP_W];
    end
  end

  always_comb begin
    mul_r = RANK_W'(a_val_r * RANK_W'(RANK_R));
    qd    = RANK_W'(a_tmp_r * RANK_W'(UNR_DIV));
    rem   = a_val_r - qd;
    if (rem >= RANK_W'(UNR_DIV)) begin
      q    = a_tmp_r + RANK_W'(1);
      m_un = IDX_W'(rem - RANK_W'(UNR_DIV));
    end else begin
      q    = a_tmp_r;
      m_un = IDX_W'(rem);
    end
    b_perm_nxt = a_perm_r;
    b_val_nxt  = a_val_r;
    if (a_ctl_r.req == REQ_RANK) begin
      b_val_nxt = mul_r + RANK_W'(a_tmp_r[IDX_W-1:0]);
    end else if (UNR_ON) begin
      b_val_nxt                = q;
      b_perm_nxt[IDX_W'(UNR_IDX)] = a_perm_r[m_un];
      b_perm_nxt[m_un]            = a_perm_r[IDX_W'(UNR_IDX)];
    end
  end

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= up_valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_ctl_r  <= up_ctl;
      a_perm_r <= a_perm_nxt;
      a_val_r  <= up_val;
      a_tmp_r  <= a_tmp_nxt;
    end
    if (b_ready && a_valid_r) begin
      b_ctl_r  <= a_ctl_r;
      b_perm_r <= b_perm_nxt;
      b_val_r  <= b_val_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_ctl   = b_ctl_r;
  assign dn_perm  = b_perm_r;
  assign dn_val   = b_val_r;

endmodule

// ===== rtl/prur_back.sv =====
module prur_back #(
  parameter int PERM_SIZE = prur_pkg::PERM_SIZE_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      up_valid,
  output logic                                      up_ready,
  input  prur_pkg::ctl_t                            up_ctl,
  input  logic [PERM_SIZE-1:0][prur_pkg::NIB_W-1:0] up_perm,
  input  logic [prur_pkg::RANK_W-1:0]               up_val,
  output logic                                      dn_valid,
  input  logic                                      dn_ready,
  output logic [prur_pkg::RANK_W-1:0]               dn_rank,
  output logic [prur_pkg::PERM_W-1:0]               dn_perm,
  output logic                                      dn_bad
);
  import prur_pkg::*;

  logic [PERM_W-1:0] packed_perm;
  logic              valid_r;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [PERM_W-1:0] perm_r, perm_nxt;
  logic              bad_r;

  // only the low positions fit the packed result
  for (genvar gi = 0; gi < PERM_NIBS; gi++) begin : g_pack
    if (gi < PERM_SIZE) begin : g_pos
      assign packed_perm[gi*NIB_W +: NIB_W] = up_perm[gi];
    end else begin : g_zero
      assign packed_perm[gi*NIB_W +: NIB_W] = '0;
    end
  end

  always_comb begin
    rank_nxt = ((up_ctl.req == REQ_RANK) && !up_ctl.bad) ? up_val : '0;
    perm_nxt = (up_ctl.req == REQ_UNRANK) ? packed_perm : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rank_r <= rank_nxt;
      perm_r <= perm_nxt;
      bad_r  <= up_ctl.bad;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rank  = rank_r;
  assign dn_perm  = perm_r;
  assign dn_bad   = bad_r;

endmodule

// ===== rtl/permutation_rank_unrank.sv =====
// throughput: one transaction per cycle while out_chan.ready does not stall it, set by the one-step-per-slot pipeline
// each slot is two register stages: rank search/swap then fold, or reciprocal
// product then quotient correction/swap; a front stage checks the input, a back
// stage formats and holds the result
// reset: synchronous active-low rst_n clears every valid bit; no clearing pass
`include "permutation_rank_unrank_defines.svh"

module permutation_rank_unrank #(
  parameter int PERM_SIZE = prur_pkg::PERM_SIZE_DEF
) (
  input logic  clk,
  input logic  rst_n,
  prur_in_if.sink   in_chan,
  prur_out_if.source out_chan
);
  import prur_pkg::*;

  // chain index 0 is the front stage, index k+1 is the output of slot k
  logic [PERM_SIZE:0]              ch_valid;
  logic [PERM_SIZE:0]              ch_ready;
  ctl_t                            ch_ctl  [PERM_SIZE+1];
  logic [PERM_SIZE-1:0][NIB_W-1:0] ch_perm [PERM_SIZE+1];
  logic [RANK_W-1:0]               ch_val  [PERM_SIZE+1];

  // input check: range and duplicate test, identity seed for unrank
  prur_front #(
    .PERM_SIZE (PERM_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_req   (in_chan.req_type),
    .up_perm  (in_chan.perm_in),
    .up_rank  (in_chan.rank_in),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_ctl   (ch_ctl[0]),
    .dn_perm  (ch_perm[0]),
    .dn_val   (ch_val[0])
  );

  // slot k does rank step r = PERM_SIZE-k and unrank step r = k+1,
  // so both request types share the same stage count
  for (genvar gk = 0; gk < PERM_SIZE; gk++) begin : g_slot
    prur_slot #(
      .PERM_SIZE (PERM_SIZE),
      .SLOT      (gk)
    ) u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[gk]),
      .up_ready (ch_ready[gk]),
      .up_ctl   (ch_ctl[gk]),
      .up_perm  (ch_perm[gk]),
      .up_val   (ch_val[gk]),
      .dn_valid (ch_valid[gk+1]),
      .dn_ready (ch_ready[gk+1]),
      .dn_ctl   (ch_ctl[gk+1]),
      .dn_perm  (ch_perm[gk+1]),
      .dn_val   (ch_val[gk+1])
    );
  end

  // result formatting and output register; rank forced to zero on a bad input
  prur_back #(
    .PERM_SIZE (PERM_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ch_valid[PERM_SIZE]),
    .up_ready (ch_ready[PERM_SIZE]),
    .up_ctl   (ch_ctl[PERM_SIZE]),
    .up_perm  (ch_perm[PERM_SIZE]),
    .up_val   (ch_val[PERM_SIZE]),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_rank  (out_chan.rank_out),
    .dn_perm  (out_chan.perm_out),
    .dn_bad   (out_chan.bad_perm)
  );

  // an accepted transaction always lands in the front stage
  `PRUR_ASSERT_NXT(a_front_load, clk, rst_n, in_chan.valid && in_chan.ready, ch_valid[0])
  // a stalled front stage keeps its transaction
  `PRUR_ASSERT_NXT(a_front_hold, clk, rst_n, ch_valid[0] && !ch_ready[0], ch_valid[0])
  // a bad permutation gives an all-zero result
  `PRUR_ASSERT_IMP(a_bad_zero, clk, rst_n, out_chan.valid && out_chan.bad_perm, (out_chan.rank_out == '0) && (out_chan.perm_out == '0))
  // a non-zero permutation result only comes from an unrank transaction
  `PRUR_ASSERT_IMP(a_unrank_only, clk, rst_n, out_chan.valid && (out_chan.perm_out != '0), !out_chan.bad_perm && (out_chan.rank_out == '0))

endmodule
